// ----- design/assert_macros.svh -----
// Assertion macros for the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
`define ASSERT_NORST(label, clk, prop) \
    label: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define ASSERT_CLK(label, clk, rst_n, prop)
`define ASSERT_NORST(label, clk, prop)
`endif
`endif

// ----- design/grwr_pkg.sv -----
package grwr_pkg;
    localparam int NumCols   = 7;
    localparam int NumRots   = 12;
    localparam int NumRegs   = 6;
    localparam int DataW     = 32;
    localparam int CoefW     = 16;
    localparam int ProdW     = DataW + CoefW;
    localparam int AddrW     = 6;
    localparam int PipeDepth = 2 * NumRots;
    localparam logic [63:0] RotReset = 64'h0000_4000_0000_4000;

    typedef logic signed [DataW-1:0] t_data;
    typedef logic signed [CoefW-1:0] t_coef;

    typedef struct packed {
        t_data [NumCols-1:0] col;
        logic                last_row;
    } t_row;

    // Column index of x for each rotation in wave order.
    function automatic logic [2:0] rot_x(input int k);
        logic [2:0] tbl [NumRots];
        tbl = '{3'd2, 3'd3, 3'd4, 3'd5, 3'd1, 3'd2, 3'd3, 3'd4, 3'd0, 3'd1, 3'd2, 3'd3};
        return tbl[k];
    endfunction

    function automatic t_data sat32(input logic signed [DataW+1:0] v);
        if (v > $signed({3'b000, {(DataW-1){1'b1}}}))
            return {1'b0, {(DataW-1){1'b1}}};
        else if (v < $signed({3'b111, {(DataW-1){1'b0}}}))
            return {1'b1, {(DataW-1){1'b0}}};
        return v[DataW-1:0];
    endfunction

    // Round to nearest, shift right by 14, saturate.
    function automatic t_data round_q14(input logic signed [ProdW-1:0] p);
        logic signed [ProdW:0] t;
        logic signed [ProdW-14:0] q;
        t = {p[ProdW-1], p} + (ProdW+1)'(8192);
        q = t[ProdW:14];
        if (q > $signed({{(ProdW-14-DataW+1){1'b0}}, {(DataW-1){1'b1}}}))
            return {1'b0, {(DataW-1){1'b1}}};
        else if (q < $signed({{(ProdW-14-DataW+1){1'b1}}, {(DataW-1){1'b0}}}))
            return {1'b1, {(DataW-1){1'b0}}};
        return q[DataW-1:0];
    endfunction
endpackage

// ----- design/grwr_row_if.sv -----
interface grwr_row_if;
    logic          valid;
    logic          ready;
    grwr_pkg::t_row data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ----- design/grwr_cell.sv -----
// One rotation: a multiply stage followed by a round, sum and saturate stage.
module grwr_cell (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic [2:0]            i_xsel,
    input  grwr_pkg::t_coef       i_cos,
    input  grwr_pkg::t_coef       i_sin,
    input  logic                  i_valid,
    input  grwr_pkg::t_row        i_row,
    output logic                  o_valid,
    output grwr_pkg::t_row        o_row
);
    logic signed [grwr_pkg::ProdW-1:0] r_cx, r_sy, r_cy, r_sx;
    grwr_pkg::t_row r_mid, r_row, n_row;
    logic r_vmid, r_vout;
    grwr_pkg::t_data x0, y0;
    logic signed [grwr_pkg::DataW+1:0] sum_x, sum_y;

    assign x0 = i_row.col[i_xsel];
    assign y0 = i_row.col[i_xsel + 3'd1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vmid <= 1'b0;
            r_vout <= 1'b0;
        end else if (i_en) begin
            r_vmid <= i_valid;
            r_vout <= r_vmid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cx  <= x0 * i_cos;
            r_sy  <= y0 * i_sin;
            r_cy  <= y0 * i_cos;
            r_sx  <= x0 * i_sin;
            r_mid <= i_row;
            r_row <= n_row;
        end
    end

    always_comb begin
        sum_x = (grwr_pkg::DataW+2)'(grwr_pkg::round_q14(r_cx))
              + (grwr_pkg::DataW+2)'(grwr_pkg::round_q14(r_sy));
        sum_y = (grwr_pkg::DataW+2)'(grwr_pkg::round_q14(r_cy))
              - (grwr_pkg::DataW+2)'(grwr_pkg::round_q14(r_sx));
        n_row = r_mid;
        n_row.col[i_xsel]        = grwr_pkg::sat32(sum_x);
        n_row.col[i_xsel + 3'd1] = grwr_pkg::sat32(sum_y);
    end

    assign o_valid = r_vout;
    assign o_row   = r_row;
endmodule

// ----- design/grwr_cfg.sv -----
// Coefficient registers behind the APB-style port.
module grwr_cfg (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [grwr_pkg::AddrW-1:0] paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready,
    output logic [63:0] o_regs [grwr_pkg::NumRegs]
);
    logic [63:0] r_regs [grwr_pkg::NumRegs];
    logic [2:0]  idx;

    assign idx    = paddr[grwr_pkg::AddrW-1:3];
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < grwr_pkg::NumRegs; i++) r_regs[i] <= grwr_pkg::RotReset;
        end else if (psel && penable && pwrite && idx < 3'(grwr_pkg::NumRegs)) begin
            r_regs[idx] <= pwdata;
        end
    end

    always_comb begin
        prdata = '0;
        if (idx < 3'(grwr_pkg::NumRegs)) prdata = r_regs[idx];
    end

    assign o_regs = r_regs;
endmodule

// ----- design/givens_rotation_wave_row.sv -----
// Givens rotation wavefront over one row of seven columns.
// Input channel i_row carries a row (columns g-2..g+4 and a last-row flag);
// output channel o_row carries the rotated row with the flag copied.
// The row passes through a chain of twelve rotation cells, each two register
// stages deep (multiply, then round/sum/saturate), followed by the output
// register. One row is accepted every cycle while the chain advances.
// The whole chain advances only while the output register is empty or its
// row is being taken, so a stalled receiver freezes every stage with no loss,
// and input ready falls only while the output register is full and held.
// The coefficient registers are written through the APB-style port, 64-bit
// data at byte address 8*i; they reset to the identity rotation (cos 1.0,
// sin 0). Reset empties the chain and output register. Coefficients should
// only change while no row is in flight.
`include "assert_macros.svh"
module givens_rotation_wave_row (
    input  logic        i_clk,
    input  logic        i_rst_n,
    grwr_row_if.sink    i_row,
    grwr_row_if.source  o_row,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [grwr_pkg::AddrW-1:0] paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);
    logic [63:0] regs [grwr_pkg::NumRegs];
    logic           v [grwr_pkg::NumRots+1];
    grwr_pkg::t_row d [grwr_pkg::NumRots+1];
    logic           en;
    logic           r_ovalid;
    grwr_pkg::t_row r_odata;

    grwr_cfg u_cfg (
        .i_clk, .i_rst_n, .psel, .penable, .pwrite, .paddr, .pwdata,
        .prdata, .pready, .o_regs(regs)
    );

    // Chain moves when the output register can take what leaves it.
    assign en          = !r_ovalid || o_row.ready;
    assign i_row.ready = en;
    assign v[0]        = i_row.valid;
    assign d[0]        = i_row.data;

    for (genvar k = 0; k < grwr_pkg::NumRots; k++) begin : g_cell
        localparam int B = (k % 2) * 32;
        grwr_cell u_cell (
            .i_clk, .i_rst_n, .i_en(en),
            .i_xsel(grwr_pkg::rot_x(k)),
            .i_cos(regs[k/2][B+15:B]),
            .i_sin(regs[k/2][B+31:B+16]),
            .i_valid(v[k]), .i_row(d[k]),
            .o_valid(v[k+1]), .o_row(d[k+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_ovalid <= 1'b0;
        else if (en) r_ovalid <= v[grwr_pkg::NumRots];
    end

    always_ff @(posedge i_clk) begin
        if (en) r_odata <= d[grwr_pkg::NumRots];
    end

    assign o_row.valid = r_ovalid;
    assign o_row.data  = r_odata;

    `ASSERT_CLK(a_hold, i_clk, i_rst_n, (r_ovalid && !o_row.ready) |=> (r_ovalid && $stable(r_odata)))
    `ASSERT_CLK(a_ready, i_clk, i_rst_n, !r_ovalid |-> i_row.ready)
    `ASSERT_CLK(a_pready, i_clk, i_rst_n, pready)
endmodule

// ----- test/grwr_row_checker.sv -----
module grwr_row_checker
    import grwr_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    input  logic                   i_in_ready,
    input  t_row                   i_in_data,
    input  logic                   i_out_valid,
    input  logic                   i_out_ready,
    input  t_row                   i_out_data,
    input  logic                   i_psel,
    input  logic                   i_penable,
    input  logic                   i_pwrite,
    input  logic                   i_pready,
    input  logic [AddrW-1:0]       i_paddr,
    input  logic [63:0]            i_pwdata,
    output int                     o_pending,
    output int                     o_errors
);
    logic [63:0] rot_coefs [NumRegs];
    t_row        rotated_rows [$];

    // Exact product, round half up at bit 14, saturate to the data width.
    function automatic longint scale_q14(input longint d, input longint c);
        longint t;
        t = (d * c + 64'sd8192) >>> 14;
        if (t > 64'sd2147483647) t = 64'sd2147483647;
        if (t < -64'sd2147483648) t = -64'sd2147483648;
        return t;
    endfunction

    function automatic longint clamp32(input longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic t_row rotate_row(input t_row r);
        longint    v [NumCols];
        longint    x0, y0, c, s;
        int        xi;
        t_row      res;
        logic [2:0] wave_x [NumRots];
        wave_x = '{3'd2, 3'd3, 3'd4, 3'd5, 3'd1, 3'd2, 3'd3, 3'd4, 3'd0, 3'd1, 3'd2, 3'd3};
        for (int k = 0; k < NumCols; k++) v[k] = longint'(r.col[k]);
        for (int k = 0; k < NumRots; k++) begin
            c  = longint'($signed(rot_coefs[k/2][(k%2)*32 +: 16]));
            s  = longint'($signed(rot_coefs[k/2][(k%2)*32 + 16 +: 16]));
            xi = wave_x[k];
            x0 = v[xi];
            y0 = v[xi+1];
            v[xi]   = clamp32(scale_q14(x0, c) + scale_q14(y0, s));
            v[xi+1] = clamp32(scale_q14(y0, c) - scale_q14(x0, s));
        end
        for (int k = 0; k < NumCols; k++) res.col[k] = v[k][31:0];
        res.last_row = r.last_row;
        return res;
    endfunction

    assign o_pending = rotated_rows.size();

    initial begin
        o_errors = 0;
        for (int i = 0; i < NumRegs; i++) rot_coefs[i] = RotReset;
    end

    always @(posedge i_clk) begin
        t_row want;
        if (i_rst_n) begin
            if (i_psel && i_penable && i_pwrite && i_pready && (i_paddr >> 3) < NumRegs)
                rot_coefs[i_paddr >> 3] = i_pwdata;
            if (i_out_valid && i_out_ready) begin
                if (rotated_rows.size() == 0) begin
                    $display("%0t: unexpected output row %h", $time, i_out_data);
                    o_errors++;
                end else begin
                    want = rotated_rows.pop_front();
                    for (int k = 0; k < NumCols; k++)
                        if (want.col[k] !== i_out_data.col[k]) begin
                            $display("%0t: column %0d expected %h actual %h", $time, k,
                                     want.col[k], i_out_data.col[k]);
                            o_errors++;
                        end
                    if (want.last_row !== i_out_data.last_row) begin
                        $display("%0t: last_row expected %b actual %b", $time,
                                 want.last_row, i_out_data.last_row);
                        o_errors++;
                    end
                end
            end
            if (i_in_valid && i_in_ready)
                rotated_rows.push_back(rotate_row(i_in_data));
        end
    end
endmodule

// ----- test/tb_givens_rotation_wave_row.sv -----
module tb_givens_rotation_wave_row;
    import grwr_pkg::*;

    localparam int IdleLimit = 5000;

    logic               i_clk;
    logic               i_rst_n;
    logic               psel, penable, pwrite;
    logic [AddrW-1:0]   paddr;
    logic [63:0]        pwdata;
    logic [63:0]        prdata;
    logic               pready;
    int                 pending, errors;
    int                 idle_cycles;
    int                 ready_mode;
    int                 sent;

    grwr_row_if in_ch ();
    grwr_row_if out_ch ();

    givens_rotation_wave_row dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_row   (in_ch.sink),
        .o_row   (out_ch.source),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    grwr_row_checker rotation_check (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_ch.valid),
        .i_in_ready  (in_ch.ready),
        .i_in_data   (in_ch.data),
        .i_out_valid (out_ch.valid),
        .i_out_ready (out_ch.ready),
        .i_out_data  (out_ch.data),
        .i_psel      (psel),
        .i_penable   (penable),
        .i_pwrite    (pwrite),
        .i_pready    (pready),
        .i_paddr     (paddr),
        .i_pwdata    (pwdata),
        .o_pending   (pending),
        .o_errors    (errors)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // The receiver changes its stall habit at the start of each phase.
    always @(posedge i_clk) begin
        int phase_cycle;
        phase_cycle = ($time / 10) % 300;
        if (phase_cycle == 0) ready_mode <= $urandom_range(0, 3);
        case (ready_mode)
            0: out_ch.ready <= 1'b1;
            1: out_ch.ready <= $urandom_range(0, 1);
            2: out_ch.ready <= ($urandom_range(0, 7) != 0);
            default: out_ch.ready <= (($time / 10) % 16) < 10;
        endcase
    end

    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || psel)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IdleLimit) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic write_coefs(input int index, input logic [63:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= AddrW'(index * 8);
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    // Keeps valid high across back-to-back transfers; the caller lowers it for a gap.
    task automatic send_row(input t_row r);
        in_ch.valid <= 1'b1;
        in_ch.data  <= r;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        sent++;
    endtask

    task automatic drain_rows();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (PipeDepth + 4) @(posedge i_clk);
    endtask

    function automatic logic [15:0] pick_coef(input int mode);
        case (mode)
            0: return 16'h4000;
            1: return 16'h8000;
            2: return 16'h7FFF;
            3: return 16'hFFFF;
            4: return 16'($signed($urandom_range(0, 32768)) - 16384);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic t_data pick_data(input int mode);
        case (mode)
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
            default: return t_data'($urandom);
        endcase
    endfunction

    task automatic load_setting(input int setting);
        logic [63:0] v;
        for (int i = 0; i < NumRegs; i++) begin
            case (setting)
                1: v = 64'h8000_8000_8000_8000;
                2: v = 64'h7FFF_7FFF_7FFF_7FFF;
                3: v = 64'hFFFF_FFFF_FFFF_FFFF;
                4: v = 64'h0;
                5: v = 64'hC000_0000_4000_C000;
                default: v = {pick_coef($urandom_range(0, 5)), pick_coef($urandom_range(0, 5)),
                              pick_coef($urandom_range(0, 5)), pick_coef($urandom_range(0, 5))};
            endcase
            write_coefs(i, v);
        end
        // Indexes past the last register must be ignored.
        write_coefs(NumRegs, 64'h1234_5678_9ABC_DEF0);
    endtask

    initial begin
        t_row r;
        int   dmode;
        sent        = 0;
        idle_cycles = 0;
        ready_mode  = 0;
        i_rst_n     = 1'b0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        in_ch.valid = 1'b0;
        in_ch.data  = '0;
        out_ch.ready = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed rows under reset coefficients, then under extreme ones.
        for (int pass = 0; pass < 2; pass++) begin
            for (int m = 0; m < 4; m++) begin
                for (int k = 0; k < NumCols; k++) r.col[k] = pick_data(m);
                r.last_row = m[0];
                send_row(r);
                for (int k = 0; k < NumCols; k++) r.col[k] = k[0] ? pick_data(0) : pick_data(1);
                r.last_row = ~m[0];
                send_row(r);
            end
            drain_rows();
            if (pass == 0) load_setting(1);
        end

        for (int setting = 2; setting < 12; setting++) begin
            load_setting(setting);
            for (int n = 0; n < 110; n++) begin
                dmode = $urandom_range(0, 9);
                for (int k = 0; k < NumCols; k++)
                    r.col[k] = pick_data(dmode < 6 ? 3 : (dmode < 8 ? 2 : $urandom_range(0, 1)));
                r.last_row = $urandom_range(0, 1);
                send_row(r);
                if (setting % 3 != 0 && $urandom_range(0, 5) == 0) begin
                    in_ch.valid <= 1'b0;
                    repeat ($urandom_range(1, 12)) @(posedge i_clk);
                end
            end
            drain_rows();
        end

        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule

// ----- sim.f -----
+incdir+design
design/grwr_pkg.sv
design/grwr_row_if.sv
design/grwr_cell.sv
design/grwr_cfg.sv
design/givens_rotation_wave_row.sv
test/grwr_row_checker.sv
test/tb_givens_rotation_wave_row.sv
